### src/assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Flag any cycle in which expr holds.
`define ASSERT_NEVER(lbl, ck, rstn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

// Require cons in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication broken");

// Require cons in the cycle after ante.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication broken");

`else

`define ASSERT_NEVER(lbl, ck, rstn, expr)
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

### src/ise_pkg.sv
`timescale 1ns / 1ps

package ise_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;
  localparam logic [1:0] FAULT_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] data_in;
    logic [POS_W-1:0]        position;
  } ise_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                    is_empty;
    logic [1:0]              fault;
  } ise_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE_RD,
    ST_TAKE_CAP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_DONE
  } ise_state_t;

endpackage

### src/indexed_stack_engine.sv
// Steps: a fault goes straight to the result; push and insert shift any entries
//   above the slot up to open a gap, then place the word; pop and remove read
//   the entry, then shift any entries above it down. Each moved entry costs one
//   memory read and one memory write on the word store. Throughput: one
//   transaction at a time; ready returns when the result is registered.
// Reset: synchronous, active-low rst_n empties the stack; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_stack_engine #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ise_pkg::ise_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ise_pkg::ise_out_t out_data
);

  localparam int AW = $clog2(DEPTH);

  // Memory port between the sequencer and the word store.
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [ise_pkg::DATA_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic signed [ise_pkg::DATA_W-1:0] mem_rdata;

  // Sequencer: decode each transaction, check faults, then walk the
  // shared stepper across the store to open or close a gap one entry
  // per read/write pair. The result register parts the two sides, so a
  // new transaction is taken while a finished result still waits.
  ise_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Word store: bottom of stack at address 0, registered read data.
  ise_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read and write never share a cycle: the shift reads in ST_SHIFT_RD and writes in ST_SHIFT_WR.
  `ASSERT_NEVER(no_rw_same_cycle, clk, rst_n, mem_we && mem_re)
  // Drop ready right after taking a transaction.
  `ASSERT_NEXT(busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // Keep every write inside the store.
  `ASSERT_IMPLIES(write_in_range, clk, rst_n, mem_we, mem_waddr <= AW'(DEPTH - 1))

endmodule

### src/ise_mem.sv
`timescale 1ns / 1ps

module ise_mem #(
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH)-1:0]                waddr,
  input  logic signed [ise_pkg::DATA_W-1:0]       wdata,
  input  logic                                    re,
  input  logic [$clog2(DEPTH)-1:0]                raddr,
  output logic signed [ise_pkg::DATA_W-1:0]       rdata
);

  logic signed [ise_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [ise_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ise_step_unit.sv
`timescale 1ns / 1ps

// Shared pointer stepper: one increment/decrement and one compare.
module ise_step_unit #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] ptr,
  input  logic [$clog2(DEPTH)-1:0] lim,
  input  logic                     up,
  output logic [$clog2(DEPTH)-1:0] src,
  output logic                     more
);

  localparam int AW = $clog2(DEPTH);

  always_comb begin
    if (up) begin
      src  = ptr + AW'(1);
      more = (ptr < lim);
    end else begin
      src  = ptr - AW'(1);
      more = (ptr > lim);
    end
  end

endmodule

### src/ise_ctrl.sv
`timescale 1ns / 1ps

module ise_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ise_pkg::ise_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ise_pkg::ise_out_t                  out_data,
  output logic                               mem_we,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr,
  output logic signed [ise_pkg::DATA_W-1:0]  mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr,
  input  logic signed [ise_pkg::DATA_W-1:0]  mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ise_pkg::POS_W;
  localparam int MW = (CW > PW) ? CW : PW;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  ise_pkg::ise_state_t state_r, state_nxt;

  logic [CW-1:0]                      count_r, count_nxt;
  logic [AW-1:0]                      ptr_r, ptr_nxt;
  logic [AW-1:0]                      lim_r, lim_nxt;
  logic                               up_r, up_nxt;
  logic signed [ise_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic signed [ise_pkg::DATA_W-1:0]  result_r, result_nxt;
  logic [1:0]                         fault_r, fault_nxt;
  logic                               empty_r, empty_nxt;
  ise_pkg::ise_out_t                  out_r, out_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic          acc;
  logic          load_out;
  logic [MW-1:0] pos_m;
  logic [MW-1:0] cnt_m;
  logic          is_rem;
  logic          cnt_zero;
  logic          cnt_full;
  logic          pos_above;
  logic [1:0]    fault_dec;
  logic [MW-1:0] rem_pos;
  logic [MW-1:0] ins_pos;
  logic [MW-1:0] rem_slot;
  logic [MW-1:0] ins_slot;
  logic [AW-1:0] step_src;
  logic          step_more;

  ise_step_unit #(.DEPTH(DEPTH)) u_step (
    .ptr  (ptr_r),
    .lim  (lim_r),
    .up   (up_r),
    .src  (step_src),
    .more (step_more)
  );

  assign acc      = in_valid && in_ready;
  assign load_out = (state_r == ise_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Request decode and fault check.
  always_comb begin
    pos_m     = MW'(in_data.position);
    cnt_m     = MW'(count_r);
    cnt_zero  = (count_r == '0);
    cnt_full  = (count_r == FULL);
    pos_above = (pos_m > cnt_m);
    is_rem    = (in_data.op == ise_pkg::OP_POP) || (in_data.op == ise_pkg::OP_REMOVE);
    rem_pos   = (in_data.op == ise_pkg::OP_POP) ? cnt_m : pos_m;
    ins_pos   = (in_data.op == ise_pkg::OP_PUSH) ? '0 : pos_m;
    rem_slot  = rem_pos - MW'(1);
    ins_slot  = cnt_m - ins_pos;
    unique case (in_data.op)
      ise_pkg::OP_PUSH: begin
        fault_dec = cnt_full ? ise_pkg::FAULT_OVER : ise_pkg::FAULT_OK;
      end
      ise_pkg::OP_POP: begin
        fault_dec = cnt_zero ? ise_pkg::FAULT_UNDER : ise_pkg::FAULT_OK;
      end
      ise_pkg::OP_REMOVE: begin
        if (cnt_zero) begin
          fault_dec = ise_pkg::FAULT_UNDER;
        end else if ((pos_m == '0) || pos_above) begin
          fault_dec = ise_pkg::FAULT_RANGE;
        end else begin
          fault_dec = ise_pkg::FAULT_OK;
        end
      end
      default: begin
        if (pos_above) begin
          fault_dec = ise_pkg::FAULT_RANGE;
        end else if (cnt_full) begin
          fault_dec = ise_pkg::FAULT_OVER;
        end else begin
          fault_dec = ise_pkg::FAULT_OK;
        end
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    up_nxt        = up_r;
    val_nxt       = val_r;
    result_nxt    = result_r;
    fault_nxt     = fault_r;
    empty_nxt     = empty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (acc) begin
      val_nxt    = in_data.data_in;
      fault_nxt  = fault_dec;
      result_nxt = '0;
      up_nxt     = is_rem;
      if (fault_dec == ise_pkg::FAULT_OK) begin
        if (is_rem) begin
          count_nxt = count_r - CW'(1);
          ptr_nxt   = rem_slot[AW-1:0];
          lim_nxt   = AW'(count_r - CW'(1));
        end else begin
          count_nxt = count_r + CW'(1);
          ptr_nxt   = AW'(count_r);
          lim_nxt   = ins_slot[AW-1:0];
        end
      end
      empty_nxt = (count_nxt == '0);
    end

    if (state_r == ise_pkg::ST_TAKE_CAP) begin
      result_nxt = mem_rdata;
    end

    if (state_r == ise_pkg::ST_SHIFT_WR) begin
      ptr_nxt = step_src;
    end

    if (load_out) begin
      out_valid_nxt     = 1'b1;
      out_nxt.data_out  = result_r;
      out_nxt.is_empty  = empty_r;
      out_nxt.fault     = fault_r;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ise_pkg::ST_IDLE: begin
        if (acc) begin
          if (fault_dec != ise_pkg::FAULT_OK) begin
            state_nxt = ise_pkg::ST_DONE;
          end else if (is_rem) begin
            state_nxt = ise_pkg::ST_TAKE_RD;
          end else begin
            state_nxt = ise_pkg::ST_SHIFT_RD;
          end
        end
      end
      ise_pkg::ST_TAKE_RD:  state_nxt = ise_pkg::ST_TAKE_CAP;
      ise_pkg::ST_TAKE_CAP: state_nxt = ise_pkg::ST_SHIFT_RD;
      ise_pkg::ST_SHIFT_RD: begin
        if (step_more) begin
          state_nxt = ise_pkg::ST_SHIFT_WR;
        end else if (up_r) begin
          state_nxt = ise_pkg::ST_DONE;
        end else begin
          state_nxt = ise_pkg::ST_PLACE;
        end
      end
      ise_pkg::ST_SHIFT_WR: state_nxt = ise_pkg::ST_SHIFT_RD;
      ise_pkg::ST_PLACE:    state_nxt = ise_pkg::ST_DONE;
      ise_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = ise_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ise_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory port and input handshake.
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = mem_rdata;
    unique case (state_r)
      ise_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ise_pkg::ST_TAKE_RD: begin
        mem_re = 1'b1;
      end
      ise_pkg::ST_SHIFT_RD: begin
        mem_re    = step_more;
        mem_raddr = step_src;
      end
      ise_pkg::ST_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      ise_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lim_r;
        mem_wdata = val_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ise_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    lim_r    <= lim_nxt;
    up_r     <= up_nxt;
    val_r    <= val_nxt;
    result_r <= result_nxt;
    fault_r  <= fault_nxt;
    empty_r  <= empty_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sim/indexed_stack_engine_checker.sv
`timescale 1ns / 1ps

module indexed_stack_engine_checker #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  ise_pkg::ise_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  ise_pkg::ise_out_t          out_data,
  output int                         mismatches,
  output int                         pending
);

  logic signed [ise_pkg::DATA_W-1:0] stack_words [DEPTH];
  int                                stack_fill;
  ise_pkg::ise_out_t                 awaited_responses [$];

  // Apply one request to the shadow stack and return the response it earns.
  function automatic ise_pkg::ise_out_t execute_stack_request(ise_pkg::ise_in_t req);
    ise_pkg::ise_out_t rsp;
    int                slot;
    rsp       = '0;
    rsp.fault = ise_pkg::FAULT_OK;
    case (req.op)
      ise_pkg::OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          rsp.fault = ise_pkg::FAULT_OVER;
        end else begin
          stack_words[stack_fill] = req.data_in;
          stack_fill++;
        end
      end
      ise_pkg::OP_POP: begin
        if (stack_fill == 0) begin
          rsp.fault = ise_pkg::FAULT_UNDER;
        end else begin
          stack_fill--;
          rsp.data_out = stack_words[stack_fill];
        end
      end
      ise_pkg::OP_REMOVE: begin
        if (stack_fill == 0) begin
          rsp.fault = ise_pkg::FAULT_UNDER;
        end else if (req.position == 0 || int'(req.position) > stack_fill) begin
          rsp.fault = ise_pkg::FAULT_RANGE;
        end else begin
          slot = int'(req.position) - 1;
          rsp.data_out = stack_words[slot];
          for (int i = slot; i + 1 < stack_fill; i++) stack_words[i] = stack_words[i + 1];
          stack_fill--;
        end
      end
      ise_pkg::OP_INSERT: begin
        // Range is checked before the full condition.
        if (int'(req.position) > stack_fill) begin
          rsp.fault = ise_pkg::FAULT_RANGE;
        end else if (stack_fill >= DEPTH) begin
          rsp.fault = ise_pkg::FAULT_OVER;
        end else begin
          slot = stack_fill - int'(req.position);
          for (int i = stack_fill; i > slot; i--) stack_words[i] = stack_words[i - 1];
          stack_words[slot] = req.data_in;
          stack_fill++;
        end
      end
    endcase
    rsp.is_empty = (stack_fill == 0);
    return rsp;
  endfunction

  always @(posedge clk) begin
    ise_pkg::ise_out_t want;
    if (!rst_n) begin
      stack_fill = 0;
      awaited_responses.delete();
    end else begin
      if (in_valid && in_ready) awaited_responses.push_back(execute_stack_request(in_data));
      if (out_valid && out_ready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected response data_out=%0d is_empty=%0b fault=%0d",
                     $time, out_data.data_out, out_data.is_empty, out_data.fault);
        end else begin
          want = awaited_responses.pop_front();
          if (out_data.data_out !== want.data_out || out_data.is_empty !== want.is_empty ||
              out_data.fault !== want.fault) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: response mismatch: expected data_out=%0d is_empty=%0b fault=%0d,",
                     $time, want.data_out, want.is_empty, want.fault);
              $display(" got data_out=%0d is_empty=%0b fault=%0d",
                       out_data.data_out, out_data.is_empty, out_data.fault);
            end
          end
        end
      end
    end
    pending = awaited_responses.size();
  end

endmodule

### sim/indexed_stack_engine_test.sv
`timescale 1ns / 1ps

module indexed_stack_engine_test;

  localparam int DEPTH        = 16;
  localparam int PHASE_ITEMS  = 455;
  // Leave wide margin over the worst transaction for stalls.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ise_pkg::ise_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ise_pkg::ise_out_t out_data;

  int mismatches;
  int pending;

  // Idle and stall odds, in percent, per cycle.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int idle_plan [4]      = '{0, 79, 0, 17};
  int stall_plan [4]     = '{0, 0, 79, 17};

  // Rough fill level, used only to steer the random requests.
  int level   = 0;
  bit filling = 1'b1;
  int idle_run = 0;

  indexed_stack_engine #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  indexed_stack_engine_checker #(
    .DEPTH(DEPTH)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Randomly stall the result channel; hold ready low through reset.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("indexed_stack_engine_test: done, errors");
      $finish;
    end
  end

  // Drive one request and hold it until the engine accepts it.
  task automatic send_request(input logic [1:0] op, input logic [31:0] value, input int pos);
    @(negedge clk);
    // Drop valid for idle cycles; a back-to-back request keeps valid high.
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data.op       = op;
    in_data.data_in  = value;
    in_data.position = pos[ise_pkg::POS_W-1:0];
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Advance the steering level the way the stack moves.
    case (op)
      ise_pkg::OP_PUSH:   if (level < DEPTH) level++;
      ise_pkg::OP_POP:    if (level > 0) level--;
      ise_pkg::OP_REMOVE: if (level > 0 && pos >= 1 && pos <= level) level--;
      ise_pkg::OP_INSERT: if (pos <= level && level < DEPTH) level++;
    endcase
  endtask

  // Mostly fill or drain runs with valid positions, plus some noise.
  task automatic send_random_request();
    int         roll;
    logic [1:0] op;
    int         pos;
    roll = $urandom_range(99);
    if (level == DEPTH && roll < 50) begin
      filling = 1'b0;
    end else if (level == 0 && roll < 50) begin
      filling = 1'b1;
    end else if (roll < 4) begin
      filling = !filling;
    end
    roll = $urandom_range(99);
    pos  = $urandom_range(31);
    if (roll < 10) begin
      op = 2'($urandom_range(3));
    end else if (filling) begin
      if (roll < 60) begin
        op = ise_pkg::OP_PUSH;
      end else begin
        op  = ise_pkg::OP_INSERT;
        pos = $urandom_range(level, 0);
      end
    end else begin
      if (roll < 55) begin
        op = ise_pkg::OP_POP;
      end else begin
        op  = ise_pkg::OP_REMOVE;
        pos = $urandom_range(level, 1);
      end
    end
    send_request(op, $urandom(), pos);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty stack: underflow and range faults, empty check before position.
    send_request(ise_pkg::OP_POP,    32'h0, 0);
    send_request(ise_pkg::OP_REMOVE, 32'h0, 0);
    send_request(ise_pkg::OP_INSERT, 32'h1234_5678, 1);
    // Fill with extremes, insert at top and under the bottom entry.
    send_request(ise_pkg::OP_INSERT, 32'h7FFF_FFFF, 0);
    send_request(ise_pkg::OP_PUSH,   32'h8000_0000, 0);
    send_request(ise_pkg::OP_INSERT, 32'h0000_0000, 2);
    send_request(ise_pkg::OP_INSERT, 32'hFFFF_FFFF, 1);
    repeat (12) send_request(ise_pkg::OP_PUSH, $urandom(), $urandom_range(31));
    // Full stack: overflow on push and insert, range before full.
    send_request(ise_pkg::OP_PUSH,   32'h5555_5555, 0);
    send_request(ise_pkg::OP_INSERT, 32'hAAAA_AAAA, 16);
    send_request(ise_pkg::OP_INSERT, 32'hAAAA_AAAA, 17);
    // Remove: zero position, top, beyond count, bottom.
    send_request(ise_pkg::OP_REMOVE, 32'h0, 0);
    send_request(ise_pkg::OP_REMOVE, 32'h0, 16);
    send_request(ise_pkg::OP_REMOVE, 32'h0, 17);
    send_request(ise_pkg::OP_REMOVE, 32'h0, 1);
    send_request(ise_pkg::OP_POP,    32'h0, 0);
    send_request(ise_pkg::OP_INSERT, 32'hFFFF_FFFF, 31);

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      sender_idle_pct    = idle_plan[phase];
      receiver_stall_pct = stall_plan[phase];
      repeat (PHASE_ITEMS) send_random_request();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("indexed_stack_engine_test: done, clean");
    end else begin
      $display("indexed_stack_engine_test: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/ise_pkg.sv
src/ise_mem.sv
src/ise_step_unit.sv
src/ise_ctrl.sv
src/indexed_stack_engine.sv
sim/indexed_stack_engine_checker.sv
sim/indexed_stack_engine_test.sv
